@@ rtl/lfupfr_pkg.sv @@
// ----------------------------------------------------------------------------
// LFU page frame replacer package
// Field widths, register reset value and result codes shared by the block.
// ----------------------------------------------------------------------------
package lfupfr_pkg;

   localparam int PAGE_NUMBER_W = 7;
   localparam int OUTCOME_W     = 2;
   localparam int FRAME_INDEX_W = 3;
   localparam int TIMER_W       = 4;

   localparam logic [TIMER_W-1:0] PROTECT_TIME_RESET = 4'd5;

   localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_FILL  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

endpackage

@@ rtl/lfupfr_if.sv @@
// ----------------------------------------------------------------------------
// LFU page frame replacer channels
// Valid/ready channels for page access requests and for access results.
// ----------------------------------------------------------------------------
interface lfupfr_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [lfupfr_pkg::PAGE_NUMBER_W-1:0]  page_number;

   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

interface lfupfr_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [lfupfr_pkg::OUTCOME_W-1:0]      outcome;
   logic [lfupfr_pkg::FRAME_INDEX_W-1:0]  frame_index;

   modport source (output valid, output outcome, output frame_index, input ready);
   modport sink   (input valid, input outcome, input frame_index, output ready);
endinterface

@@ rtl/lfupfr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lfupfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

@@ rtl/lfu_page_frame_replacer.sv @@
// ----------------------------------------------------------------------------
// LFU page frame replacer
// Frame table with use counts and protection timers, held in one RAM.
// ----------------------------------------------------------------------------
// Usage: one page access is taken per transfer on req_bus; exactly one
// result (hit, fill of a free frame, or eviction, plus the frame index) is
// returned per access on rsp_bus. csr_we/csr_wdata write the protection
// time and may only be used while the block is idle.
// Operation: an access makes one pass over the frame table, one RAM read per
// frame, after the page number has been reduced by repeated subtraction of
// PAGES (no subtraction when PAGES >= 128). The next request is taken once
// the previous one is written back, so accesses are handled one at a time.
// The result register decouples the two sides: a new request is taken
// while a result still waits, and the write-back of that request holds
// until the waiting result has been transferred.
// Reset: all frames become free at once (valid bits in flops), the
// protection time returns to 5 and no result is pending.
// ----------------------------------------------------------------------------
module lfu_page_frame_replacer #(
   parameter int FRAMES      = 8,
   parameter int PAGES       = 128,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [lfupfr_pkg::TIMER_W-1:0]   csr_wdata,
   lfupfr_req_if.sink                       req_bus,
   lfupfr_rsp_if.source                     rsp_bus
);

   localparam int IDX_W    = $clog2(FRAMES);
   localparam int PAGE_W   = $clog2(PAGES);
   localparam int TIMER_W  = lfupfr_pkg::TIMER_W;
   localparam int PN_W     = lfupfr_pkg::PAGE_NUMBER_W;
   localparam int COUNT_LSB = TIMER_W;
   localparam int PAGE_LSB  = TIMER_W + COUNT_WIDTH;
   localparam int WORD_W    = PAGE_W + COUNT_WIDTH + TIMER_W;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_UPDATE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [TIMER_W-1:0]     protect_time_ff;
   logic [FRAMES-1:0]      valid_ff;
   logic [PN_W-1:0]        page_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic                   d_vld_ff;
   logic [IDX_W-1:0]       d_idx_ff;

   logic                   hit_found_ff;
   logic [IDX_W-1:0]       hit_idx_ff;
   logic [COUNT_WIDTH-1:0] hit_count_ff;
   logic [TIMER_W-1:0]     hit_timer_ff;
   logic                   free_found_ff;
   logic [IDX_W-1:0]       free_idx_ff;
   logic                   unp_found_ff;
   logic [IDX_W-1:0]       unp_idx_ff;
   logic [COUNT_WIDTH-1:0] unp_min_ff;
   logic [IDX_W-1:0]       all_idx_ff;
   logic [COUNT_WIDTH-1:0] all_min_ff;

   logic                                rsp_valid_ff;
   logic [lfupfr_pkg::OUTCOME_W-1:0]    outcome_ff;
   logic [lfupfr_pkg::FRAME_INDEX_W-1:0] frame_ff;

   // RAM ports
   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   logic [WORD_W-1:0]      ram_wdata;
   logic [WORD_W-1:0]      ram_rdata;

   // Entry returned by the RAM this cycle
   logic                   e_valid;
   logic [PAGE_W-1:0]      e_page;
   logic [COUNT_WIDTH-1:0] e_count;
   logic [TIMER_W-1:0]     e_timer;
   logic [TIMER_W-1:0]     e_timer_dec;
   logic                   e_hit;

   // Update decision
   logic                             out_free;
   logic                             update_go;
   logic [IDX_W-1:0]                 target;
   logic [lfupfr_pkg::OUTCOME_W-1:0] outcome;
   logic [COUNT_WIDTH-1:0]           new_count;
   logic [TIMER_W-1:0]               new_timer;
   logic                             page_big;
   logic                             req_take;

   lfupfr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (FRAMES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (rd_idx_ff),
      .rdata (ram_rdata)
   );

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign req_take            = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.outcome     = outcome_ff;
   assign rsp_bus.frame_index = frame_ff;

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign update_go = (state_ff == ST_UPDATE) && out_free;
   assign page_big  = 32'(page_ff) >= 32'(PAGES);

   // Free frames read as all zero; their RAM contents are never trusted.
   always_comb begin
      e_valid     = valid_ff[d_idx_ff];
      e_page      = e_valid ? ram_rdata[PAGE_LSB +: PAGE_W] : '0;
      e_count     = e_valid ? ram_rdata[COUNT_LSB +: COUNT_WIDTH] : '0;
      e_timer     = e_valid ? ram_rdata[0 +: TIMER_W] : '0;
      e_timer_dec = (e_timer == '0) ? '0 : e_timer - 1'b1;
      e_hit       = e_valid && (e_page == PAGE_W'(page_ff));
   end

   always_comb begin
      target    = all_idx_ff;
      outcome   = lfupfr_pkg::OUTCOME_EVICT;
      new_count = COUNT_WIDTH'(1);
      new_timer = (protect_time_ff == '0) ? '0 : protect_time_ff - 1'b1;
      if (hit_found_ff) begin
         target    = hit_idx_ff;
         outcome   = lfupfr_pkg::OUTCOME_HIT;
         new_count = (hit_count_ff == '1) ? hit_count_ff : hit_count_ff + 1'b1;
         new_timer = hit_timer_ff;
      end else if (free_found_ff) begin
         target  = free_idx_ff;
         outcome = lfupfr_pkg::OUTCOME_FILL;
      end else if (unp_found_ff) begin
         target = unp_idx_ff;
      end
   end

   // The scan writes every resident frame back with its timer aged; the
   // update then overwrites the chosen frame. The two never share a cycle.
   always_comb begin
      ram_we    = d_vld_ff && e_valid;
      ram_waddr = d_idx_ff;
      ram_wdata = {e_page, e_count, e_timer_dec};
      if (update_go) begin
         ram_we    = 1'b1;
         ram_waddr = target;
         ram_wdata = {PAGE_W'(page_ff), new_count, new_timer};
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (!page_big) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff == IDX_W'(FRAMES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         protect_time_ff <= lfupfr_pkg::PROTECT_TIME_RESET;
         valid_ff        <= '0;
         d_vld_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rd_idx_ff       <= '0;
         hit_found_ff    <= 1'b0;
         free_found_ff   <= 1'b0;
         unp_found_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         d_vld_ff <= (state_ff == ST_SCAN);
         if (csr_we) begin
            protect_time_ff <= csr_wdata;
         end
         if (req_take) begin
            hit_found_ff  <= 1'b0;
            free_found_ff <= 1'b0;
            unp_found_ff  <= 1'b0;
            rd_idx_ff     <= '0;
         end
         if (state_ff == ST_SCAN && rd_idx_ff != IDX_W'(FRAMES - 1)) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
         if (d_vld_ff) begin
            if (e_hit && !hit_found_ff) begin
               hit_found_ff <= 1'b1;
            end
            if (!e_valid && !free_found_ff) begin
               free_found_ff <= 1'b1;
            end
            if (e_timer == '0 && (!unp_found_ff || e_count < unp_min_ff)) begin
               unp_found_ff <= 1'b1;
            end
         end
         if (update_go) begin
            valid_ff[target] <= 1'b1;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      d_idx_ff <= rd_idx_ff;
      if (req_take) begin
         page_ff <= req_bus.page_number;
      end else if (state_ff == ST_REDUCE && page_big) begin
         page_ff <= page_ff - PN_W'(PAGES);
      end
      if (d_vld_ff) begin
         if (e_hit && !hit_found_ff) begin
            hit_idx_ff   <= d_idx_ff;
            hit_count_ff <= e_count;
            hit_timer_ff <= e_timer_dec;
         end
         if (!e_valid && !free_found_ff) begin
            free_idx_ff <= d_idx_ff;
         end
         if (e_timer == '0 && (!unp_found_ff || e_count < unp_min_ff)) begin
            unp_idx_ff <= d_idx_ff;
            unp_min_ff <= e_count;
         end
         if (d_idx_ff == '0 || e_count < all_min_ff) begin
            all_idx_ff <= d_idx_ff;
            all_min_ff <= e_count;
         end
      end
      if (update_go) begin
         outcome_ff <= outcome;
         frame_ff   <= lfupfr_pkg::FRAME_INDEX_W'(target);
      end
   end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// LFU page frame replacer testbench
// Drives page accesses through the request channel and predicts every
// result with a mirror of the frame table. The run covers free-frame fills,
// hits, evictions with and without protected frames, and a heavily used
// frame that must survive a run of misses. It then runs random access
// streams under several protection times, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAMES          = 8;
   localparam int PAGES           = 128;
   localparam int COUNT_WIDTH     = 16;
   localparam int LATENCY         = FRAMES + 3;
   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int HEAVY_HITS      = 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SEGMENT_ITEMS   = 254;

   typedef logic [lfupfr_pkg::PAGE_NUMBER_W-1:0] page_type;
   typedef logic [lfupfr_pkg::OUTCOME_W-1:0]     outcome_type;
   typedef logic [lfupfr_pkg::FRAME_INDEX_W-1:0] frame_type;
   typedef logic [lfupfr_pkg::TIMER_W-1:0]       timer_type;
   typedef logic [COUNT_WIDTH-1:0]               count_type;

   typedef struct packed {
      outcome_type outcome;
      frame_type   frame;
   } access_result_type;

   // Mirror of the frame table: predicts the result of each accepted access
   // and holds the results still owed by the block.
   class frame_table_mirror_type;
      bit                resident [FRAMES];
      page_type          page_of  [FRAMES];
      count_type         uses     [FRAMES];
      timer_type         shield   [FRAMES];
      timer_type         shield_time;
      access_result_type expected_results [$];
      int                mismatches;
      int                hits;
      int                fills;
      int                evictions;
      int                forced_evictions;
      int                saturated_hits;

      function new();
         shield_time = lfupfr_pkg::PROTECT_TIME_RESET;
         foreach (resident[i]) begin
            resident[i] = 1'b0;
            page_of[i]  = '0;
            uses[i]     = '0;
            shield[i]   = '0;
         end
      endfunction

      function int least_used(bit unshielded_only);
         int best;
         best = -1;
         for (int i = 0; i < FRAMES; i++) begin
            if (!(unshielded_only && shield[i] != '0) &&
                (best < 0 || uses[i] < uses[best]))
               best = i;
         end
         return best;
      endfunction

      function access_result_type predict_access(page_type page);
         access_result_type result;
         int                slot;
         slot = -1;
         for (int i = 0; i < FRAMES; i++) begin
            if (slot < 0 && resident[i] && page_of[i] == page)
               slot = i;
         end
         if (slot >= 0) begin
            result.outcome = lfupfr_pkg::OUTCOME_HIT;
            hits++;
            if (uses[slot] == '1)
               saturated_hits++;
            else
               uses[slot]++;
         end else begin
            for (int i = 0; i < FRAMES; i++) begin
               if (slot < 0 && !resident[i])
                  slot = i;
            end
            if (slot >= 0) begin
               result.outcome = lfupfr_pkg::OUTCOME_FILL;
               fills++;
            end else begin
               result.outcome = lfupfr_pkg::OUTCOME_EVICT;
               evictions++;
               slot = least_used(1'b1);
               // With every frame still protected, the least-used frame
               // overall goes.
               if (slot < 0) begin
                  forced_evictions++;
                  slot = least_used(1'b0);
               end
            end
            resident[slot] = 1'b1;
            page_of[slot]  = page;
            uses[slot]     = count_type'(1);
            shield[slot]   = shield_time;
         end
         // The timer of a frame filled by this access counts down as well.
         for (int i = 0; i < FRAMES; i++) begin
            if (shield[i] != '0)
               shield[i]--;
         end
         result.frame = frame_type'(slot);
         return result;
      endfunction

      function void note_access(page_type page);
         expected_results.push_back(predict_access(page));
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 40)
            $display("MISMATCH at %0t ns: %s", $time, what);
      endtask

      task check_result(outcome_type outcome, frame_type frame);
         access_result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result outcome %0d frame %0d with no access pending",
                                      outcome, frame));
         end else begin
            want = expected_results.pop_front();
            if (outcome !== want.outcome)
               report_mismatch($sformatf("outcome %0d, expected %0d (frame %0d)",
                                         outcome, want.outcome, want.frame));
            if (frame !== want.frame)
               report_mismatch($sformatf("frame %0d, expected %0d (outcome %0d)",
                                         frame, want.frame, want.outcome));
         end
      endtask
   endclass

   logic      clock     = 1'b0;
   logic      reset     = 1'b1;
   logic      csr_we    = 1'b0;
   timer_type csr_wdata = '0;

   lfupfr_req_if req_bus ();
   lfupfr_rsp_if rsp_bus ();

   frame_table_mirror_type mirror;
   bit                     idling_on    = 1'b1;
   bit                     hold_request = 1'b0;
   int                     cycle_count  = 0;

   lfu_page_frame_replacer #(
      .FRAMES      (FRAMES),
      .PAGES       (PAGES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("lfu_page_frame_replacer regression: fail");
         $finish;
      end
   end

   // Result side: checks each transfer and stalls in random bursts. A long
   // hold-off, when requested, is counted down here.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            mirror.check_result(rsp_bus.outcome, rsp_bus.frame_index);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_OFF_CYCLES;
         end else if (stall_left == 0 && idling_on && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 15);
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic offer_page(page_type page);
      int gap;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.page_number <= page;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      mirror.note_access(page);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (mirror.expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_protect_time(timer_type value);
      wait_drained();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      mirror.shield_time = value;
   endtask

   // Mostly a small hot set of pages so that hits and evictions mix, with
   // uniformly random pages in between.
   task automatic run_access_stream(int count, bit with_hold_off);
      page_type hot [20];
      int       hot_size;
      page_type page;
      hot_size = $urandom_range(4, 20);
      foreach (hot[i]) hot[i] = page_type'($urandom_range(0, PAGES - 1));
      for (int n = 0; n < count; n++) begin
         if (with_hold_off && n == count / 3)
            hold_request = 1'b1;
         if ($urandom_range(0, 4) == 0)
            page = page_type'($urandom_range(0, PAGES - 1));
         else
            page = hot[$urandom_range(0, hot_size - 1)];
         offer_page(page);
      end
   endtask

   initial begin
      timer_type stream_settings [7];
      mirror = new();
      req_bus.valid       <= 1'b0;
      req_bus.page_number <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset protection time: fill all frames, hit, then evict.
      offer_page(page_type'(0));
      offer_page(page_type'(PAGES - 1));
      offer_page(page_type'(0));
      for (int p = 1; p <= 6; p++) offer_page(page_type'(p));
      offer_page(page_type'(0));
      offer_page(page_type'(PAGES - 1));
      offer_page(7'h2A);
      offer_page(7'h55);
      offer_page(7'h2A);

      // Longest protection: eight evictions in a row leave every frame
      // protected, so the next misses fall back to the least-used frame.
      write_protect_time(4'd15);
      for (int p = 16; p < 26; p++) offer_page(page_type'(p));

      // No protection: give one frame a high use count, then miss
      // repeatedly; that frame must never be the victim.
      write_protect_time(4'd0);
      idling_on = 1'b0;
      repeat (HEAVY_HITS) offer_page(7'h55);
      for (int p = 'h60; p < 'h70; p++) offer_page(page_type'(p));
      idling_on = 1'b1;

      stream_settings = '{4'd1, 4'd15, 4'd8, timer_type'($urandom_range(0, 15)), 4'd0, 4'd3,
                          timer_type'($urandom_range(0, 15))};
      foreach (stream_settings[s]) begin
         write_protect_time(stream_settings[s]);
         if (s == 6)
            idling_on = 1'b0;
         run_access_stream(SEGMENT_ITEMS, s == 1);
      end

      wait_drained();
      repeat (4 * LATENCY) @(posedge clock);

      $display("Covered %0d accesses: %0d hits, %0d fills, %0d evictions (%0d all protected).",
               mirror.hits + mirror.fills + mirror.evictions, mirror.hits, mirror.fills,
               mirror.evictions, mirror.forced_evictions);
      $display("Hits at the count ceiling: %0d; protection times 0, 15 and others; %0d mismatches.",
               mirror.saturated_hits, mirror.mismatches);
      if (mirror.mismatches == 0)
         $display("lfu_page_frame_replacer regression: pass");
      else
         $display("lfu_page_frame_replacer regression: fail");
      $finish;
   end

endmodule
